// ===== design/seismic_event_trigger_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// Seismic event trigger sequencer assertion macros
// Shared property forms for the concurrent checks in the top level.
// ----------------------------------------------------------------------------
`ifndef SEISMIC_EVENT_TRIGGER_SEQUENCER_DEFINES_SVH
`define SEISMIC_EVENT_TRIGGER_SEQUENCER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SETSEQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SETSEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/setseq_pkg.sv =====
// ----------------------------------------------------------------------------
// Seismic event trigger sequencer package
// Shared widths, types, codes and helper functions.
// ----------------------------------------------------------------------------
package setseq_pkg;

  localparam int RAW_W     = 16;
  localparam int SAMPLE_W  = 12;
  localparam int LEVEL_W   = 12;
  localparam int RECLEN_W  = 24;
  localparam int MODES_W   = 4;
  localparam int CALCNT_W  = 16;
  localparam int MANCNT_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam int CAL_UNIT = 4;

  localparam logic [SAMPLE_W-1:0] MID_SCALE = 12'h800;

  // Points of the calibration pulse sequence, counted down from the start.
  localparam logic [CALCNT_W-1:0] CAL_START_CNT  = CALCNT_W'(100 * CAL_UNIT);
  localparam logic [CALCNT_W-1:0] CAL_SIG_LOW    = CALCNT_W'(91 * CAL_UNIT);
  localparam logic [CALCNT_W-1:0] CAL_SIG_HIGH   = CALCNT_W'(73 * CAL_UNIT);
  localparam logic [CALCNT_W-1:0] CAL_ENABLE_LOW = CALCNT_W'(64 * CAL_UNIT);

  localparam logic [MANCNT_W-1:0] MANUAL_END_CNT = MANCNT_W'(99);

  localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = 12'h800;
  localparam logic [RECLEN_W-1:0] RECLEN_RESET = RECLEN_W'(1024);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    MARK_NONE      = 3'd0,
    MARK_TRIGGER   = 3'd1,
    MARK_ALARM1    = 3'd2,
    MARK_ALARM2    = 3'd3,
    MARK_CAL_START = 3'd4,
    MARK_CAL_END   = 3'd5
  } marker_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIG_SEIS  = 3'd0,
    REG_TRIG_AIR   = 3'd1,
    REG_REC_LEN    = 3'd2,
    REG_ALARM_MODE = 3'd3,
    REG_A1_SEIS    = 3'd4,
    REG_A1_AIR     = 3'd5,
    REG_A2_SEIS    = 3'd6,
    REG_A2_AIR     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  trig_seis;
    logic [LEVEL_W-1:0]  trig_air;
    logic [RECLEN_W-1:0] record_length;
    logic [MODES_W-1:0]  alarm_modes;
    logic [LEVEL_W-1:0]  a1_seis;
    logic [LEVEL_W-1:0]  a1_air;
    logic [LEVEL_W-1:0]  a2_seis;
    logic [LEVEL_W-1:0]  a2_air;
  } cfg_t;

  // One classified sample set on its way from the front to the back.
  typedef struct packed {
    logic [SAMPLE_W-1:0] air;
    logic [SAMPLE_W-1:0] seis1;
    logic [SAMPLE_W-1:0] seis2;
    logic [SAMPLE_W-1:0] seis3;
    logic                manual_cal;
    logic                trig_hit;
    logic                alarm1_hit;
    logic                alarm2_hit;
  } item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  // Distance from mid-scale; 0x800 itself fits in 12 bits.
  function automatic logic [LEVEL_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
    logic [LEVEL_W-1:0] m;
    if (s >= MID_SCALE) begin
      m = s - MID_SCALE;
    end else begin
      m = MID_SCALE - s;
    end
    return m;
  endfunction

endpackage

// ===== design/setseq_front.sv =====
// ----------------------------------------------------------------------------
// Sequencer front stage
// Accepts a raw sample set, cuts it to 12 bits and classifies it against
// the trigger and alarm levels.
// ----------------------------------------------------------------------------
module setseq_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [setseq_pkg::RAW_W-1:0]       air_raw,
  input  logic [setseq_pkg::RAW_W-1:0]       seis1_raw,
  input  logic [setseq_pkg::RAW_W-1:0]       seis2_raw,
  input  logic [setseq_pkg::RAW_W-1:0]       seis3_raw,
  input  logic                               manual_cal,
  input  setseq_pkg::cfg_t                   cfg,
  input  logic                               q_ready,
  output logic                               f_valid,
  output setseq_pkg::item_t                  f_item
);

  logic [setseq_pkg::SAMPLE_W-1:0] s_air, s_seis1, s_seis2, s_seis3;
  logic [setseq_pkg::LEVEL_W-1:0]  m_air, m_seis1, m_seis2, m_seis3;
  logic                            trig_seis, a1_seis, a2_seis;
  logic                            trig_air, a1_air, a2_air;
  logic                            load;
  setseq_pkg::item_t               item_next;

  assign s_air   = air_raw[setseq_pkg::RAW_W-1:setseq_pkg::RAW_W-setseq_pkg::SAMPLE_W];
  assign s_seis1 = seis1_raw[setseq_pkg::RAW_W-1:setseq_pkg::RAW_W-setseq_pkg::SAMPLE_W];
  assign s_seis2 = seis2_raw[setseq_pkg::RAW_W-1:setseq_pkg::RAW_W-setseq_pkg::SAMPLE_W];
  assign s_seis3 = seis3_raw[setseq_pkg::RAW_W-1:setseq_pkg::RAW_W-setseq_pkg::SAMPLE_W];

  assign m_air   = setseq_pkg::magnitude(s_air);
  assign m_seis1 = setseq_pkg::magnitude(s_seis1);
  assign m_seis2 = setseq_pkg::magnitude(s_seis2);
  assign m_seis3 = setseq_pkg::magnitude(s_seis3);

  assign trig_seis = (m_seis1 > cfg.trig_seis) || (m_seis2 > cfg.trig_seis) ||
                     (m_seis3 > cfg.trig_seis);
  assign a1_seis   = (m_seis1 > cfg.a1_seis) || (m_seis2 > cfg.a1_seis) ||
                     (m_seis3 > cfg.a1_seis);
  assign a2_seis   = (m_seis1 > cfg.a2_seis) || (m_seis2 > cfg.a2_seis) ||
                     (m_seis3 > cfg.a2_seis);
  assign trig_air  = m_air > cfg.trig_air;
  assign a1_air    = m_air > cfg.a1_air;
  assign a2_air    = m_air > cfg.a2_air;

  always_comb begin
    item_next.air        = s_air;
    item_next.seis1      = s_seis1;
    item_next.seis2      = s_seis2;
    item_next.seis3      = s_seis3;
    item_next.manual_cal = manual_cal;
    item_next.trig_hit   = trig_seis || trig_air;
    // Mode bit 0 of each pair enables the seismic test, bit 1 the air test.
    item_next.alarm1_hit = (cfg.alarm_modes[0] && a1_seis) || (cfg.alarm_modes[1] && a1_air);
    item_next.alarm2_hit = (cfg.alarm_modes[2] && a2_seis) || (cfg.alarm_modes[3] && a2_air);
  end

  assign in_stall = f_valid && !q_ready;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (load) begin
      f_valid <= 1'b1;
    end else if (q_ready) begin
      f_valid <= 1'b0;
    end
    if (load) begin
      f_item <= item_next;
    end
  end

endmodule

// ===== design/setseq_queue.sv =====
// ----------------------------------------------------------------------------
// Sequencer item queue
// Short first-in first-out buffer between the front and back stages.
// ----------------------------------------------------------------------------
module setseq_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  setseq_pkg::item_t     push_item,
  input  logic                  pop,
  output setseq_pkg::item_t     pop_item,
  output setseq_pkg::q_status_t status
);

  setseq_pkg::item_t                 entries [setseq_pkg::QUEUE_DEPTH];
  logic [setseq_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [setseq_pkg::QCNT_W-1:0]     count;
  logic                              push, pop_en;

  assign status.valid = count != '0;
  assign status.full  = count == setseq_pkg::QCNT_W'(setseq_pkg::QUEUE_DEPTH);
  assign push_ready   = !status.full;
  assign push         = push_valid && push_ready;
  assign pop_en       = pop && status.valid;
  assign pop_item     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == setseq_pkg::QPTR_W'(setseq_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop_en) begin
        rd_ptr <= (rd_ptr == setseq_pkg::QPTR_W'(setseq_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop_en) begin
        count <= count + 1'b1;
      end else if (pop_en && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== design/setseq_back.sv =====
// ----------------------------------------------------------------------------
// Sequencer back stage
// Runs the recording and calibration sequence and holds the result register.
// ----------------------------------------------------------------------------
module setseq_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  setseq_pkg::item_t                   q_item,
  output logic                                pop,
  input  logic [setseq_pkg::RECLEN_W-1:0]     record_length,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [setseq_pkg::SAMPLE_W-1:0]     air_out,
  output logic [setseq_pkg::SAMPLE_W-1:0]     seis1_out,
  output logic [setseq_pkg::SAMPLE_W-1:0]     seis2_out,
  output logic [setseq_pkg::SAMPLE_W-1:0]     seis3_out,
  output logic [2:0]                          marker,
  output logic                                cal_enable,
  output logic                                cal_signal
);

  logic                              recording, recording_next;
  logic [setseq_pkg::RECLEN_W-1:0]   record_remaining, record_remaining_next;
  logic                              cal_active, cal_active_next;
  logic [setseq_pkg::CALCNT_W-1:0]   cal_remaining, cal_remaining_next;
  logic [setseq_pkg::MANCNT_W-1:0]   manual_count, manual_count_next;
  logic                              cal_enable_level, cal_enable_level_next;
  logic                              cal_signal_level, cal_signal_level_next;
  setseq_pkg::marker_t               marker_next;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    recording_next        = recording;
    record_remaining_next = record_remaining;
    cal_active_next       = cal_active;
    cal_remaining_next    = cal_remaining;
    manual_count_next     = manual_count;
    cal_enable_level_next = cal_enable_level;
    cal_signal_level_next = cal_signal_level;
    marker_next           = setseq_pkg::MARK_NONE;

    if (q_item.manual_cal) begin
      if (manual_count == '0) begin
        marker_next = setseq_pkg::MARK_CAL_START;
      end else if (manual_count == setseq_pkg::MANUAL_END_CNT) begin
        marker_next = setseq_pkg::MARK_CAL_END;
      end
      manual_count_next = manual_count + 1'b1;
    end else begin
      manual_count_next = '0;
      priority if (!recording && !cal_active) begin
        if (q_item.trig_hit) begin
          recording_next        = 1'b1;
          record_remaining_next = record_length;
          marker_next           = setseq_pkg::MARK_TRIGGER;
        end
      end else if (recording && record_remaining != '0) begin
        record_remaining_next = record_remaining - 1'b1;
        if (q_item.alarm2_hit) begin
          marker_next = setseq_pkg::MARK_ALARM2;
        end else if (q_item.alarm1_hit) begin
          marker_next = setseq_pkg::MARK_ALARM1;
        end
      end else if (recording) begin
        recording_next        = 1'b0;
        cal_active_next       = 1'b1;
        cal_remaining_next    = setseq_pkg::CAL_START_CNT;
        cal_enable_level_next = 1'b1;
        marker_next           = setseq_pkg::MARK_CAL_START;
      end else if (cal_remaining != '0) begin
        if (cal_remaining == setseq_pkg::CAL_START_CNT) begin
          cal_enable_level_next = 1'b1;
          cal_signal_level_next = 1'b1;
        end
        if (cal_remaining == setseq_pkg::CAL_SIG_LOW) begin
          cal_signal_level_next = 1'b0;
        end
        if (cal_remaining == setseq_pkg::CAL_SIG_HIGH) begin
          cal_signal_level_next = 1'b1;
        end
        if (cal_remaining == setseq_pkg::CAL_ENABLE_LOW) begin
          cal_enable_level_next = 1'b0;
        end
        cal_remaining_next = cal_remaining - 1'b1;
      end else begin
        cal_active_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recording        <= 1'b0;
      record_remaining <= '0;
      cal_active       <= 1'b0;
      cal_remaining    <= '0;
      manual_count     <= '0;
      cal_enable_level <= 1'b0;
      cal_signal_level <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        recording        <= recording_next;
        record_remaining <= record_remaining_next;
        cal_active       <= cal_active_next;
        cal_remaining    <= cal_remaining_next;
        manual_count     <= manual_count_next;
        cal_enable_level <= cal_enable_level_next;
        cal_signal_level <= cal_signal_level_next;
        out_valid        <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (pop) begin
      air_out    <= q_item.air;
      seis1_out  <= q_item.seis1;
      seis2_out  <= q_item.seis2;
      seis3_out  <= q_item.seis3;
      marker     <= marker_next;
      cal_enable <= cal_enable_level_next;
      cal_signal <= cal_signal_level_next;
    end
  end

endmodule

// ===== design/seismic_event_trigger_sequencer.sv =====
// A sample set passes the front register, the queue and the output register in turn,
// and its result is offered once it sits in the output register.
// Throughput: one sample set per cycle; the back stage updates its whole state as it
// pops each item, so items flow without gaps while the output is not stalled.
// Reset (synchronous, rst high) empties the front register, the queue and the output
// register, clears the sequence state and loads the register defaults.
// ----------------------------------------------------------------------------
// Seismic event trigger sequencer
// Cuts four-channel sample sets to 12 bits, detects triggers and alarms,
// and sequences the calibration pulse that follows each recording.
// ----------------------------------------------------------------------------
`include "seismic_event_trigger_sequencer_defines.svh"

module seismic_event_trigger_sequencer (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [setseq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [setseq_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Sample set input channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [setseq_pkg::RAW_W-1:0]          air_raw,
  input  logic [setseq_pkg::RAW_W-1:0]          seis1_raw,
  input  logic [setseq_pkg::RAW_W-1:0]          seis2_raw,
  input  logic [setseq_pkg::RAW_W-1:0]          seis3_raw,
  input  logic                                  manual_cal,
  // Result output channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [setseq_pkg::SAMPLE_W-1:0]       air_out,
  output logic [setseq_pkg::SAMPLE_W-1:0]       seis1_out,
  output logic [setseq_pkg::SAMPLE_W-1:0]       seis2_out,
  output logic [setseq_pkg::SAMPLE_W-1:0]       seis3_out,
  output logic [2:0]                            marker,
  output logic                                  cal_enable,
  output logic                                  cal_signal
);

  setseq_pkg::cfg_t      cfg;
  logic                  f_valid;
  setseq_pkg::item_t     f_item;
  logic                  q_ready;
  setseq_pkg::item_t     q_item;
  setseq_pkg::q_status_t q_stat;
  logic                  q_pop;
  logic                  cfg_we;

  // The register file takes a write in every cycle; the user must write only while
  // the block is idle (unenforced), so no item sees a half-updated configuration.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trig_seis     <= setseq_pkg::LEVEL_RESET;
      cfg.trig_air      <= setseq_pkg::LEVEL_RESET;
      cfg.record_length <= setseq_pkg::RECLEN_RESET;
      cfg.alarm_modes   <= '0;
      cfg.a1_seis       <= setseq_pkg::LEVEL_RESET;
      cfg.a1_air        <= setseq_pkg::LEVEL_RESET;
      cfg.a2_seis       <= setseq_pkg::LEVEL_RESET;
      cfg.a2_air        <= setseq_pkg::LEVEL_RESET;
    end else if (cfg_we) begin
      unique case (setseq_pkg::cfg_idx_t'(cfg_index))
        setseq_pkg::REG_TRIG_SEIS:  cfg.trig_seis     <= cfg_data[setseq_pkg::LEVEL_W-1:0];
        setseq_pkg::REG_TRIG_AIR:   cfg.trig_air      <= cfg_data[setseq_pkg::LEVEL_W-1:0];
        setseq_pkg::REG_REC_LEN:    cfg.record_length <= cfg_data[setseq_pkg::RECLEN_W-1:0];
        setseq_pkg::REG_ALARM_MODE: cfg.alarm_modes   <= cfg_data[setseq_pkg::MODES_W-1:0];
        setseq_pkg::REG_A1_SEIS:    cfg.a1_seis       <= cfg_data[setseq_pkg::LEVEL_W-1:0];
        setseq_pkg::REG_A1_AIR:     cfg.a1_air        <= cfg_data[setseq_pkg::LEVEL_W-1:0];
        setseq_pkg::REG_A2_SEIS:    cfg.a2_seis       <= cfg_data[setseq_pkg::LEVEL_W-1:0];
        setseq_pkg::REG_A2_AIR:     cfg.a2_air        <= cfg_data[setseq_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // The front stage classifies every sample set against all level sets at
  // once, so the back stage only has to choose among precomputed flags.
  setseq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .air_raw    (air_raw),
    .seis1_raw  (seis1_raw),
    .seis2_raw  (seis2_raw),
    .seis3_raw  (seis3_raw),
    .manual_cal (manual_cal),
    .cfg        (cfg),
    .q_ready    (q_ready),
    .f_valid    (f_valid),
    .f_item     (f_item)
  );

  // The queue decouples the two stages: input stall depends only on the front valid
  // flag and the queue's registered fill level, never directly on out_stall.
  setseq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (q_ready),
    .push_item  (f_item),
    .pop        (q_pop),
    .pop_item   (q_item),
    .status     (q_stat)
  );

  // The back stage owns the recording and calibration state and drives the
  // output register; it advances its state once per transferred item.
  setseq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_stat.valid),
    .q_item        (q_item),
    .pop           (q_pop),
    .record_length (cfg.record_length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .air_out       (air_out),
    .seis1_out     (seis1_out),
    .seis2_out     (seis2_out),
    .seis3_out     (seis3_out),
    .marker        (marker),
    .cal_enable    (cal_enable),
    .cal_signal    (cal_signal)
  );

  // An accepted sample set is always held by the front register next cycle.
  `SETSEQ_ASSERT_NEXT(a_front_catch, clk, rst, in_valid && !in_stall, f_valid,
    "accepted sample set was not captured by the front stage")

  // A full queue must offer an item to the back stage.
  `SETSEQ_ASSERT_SAME(a_full_valid, clk, rst, q_stat.full, q_stat.valid,
    "queue reports full while empty")

  // The back stage only pulls from a queue that holds something.
  `SETSEQ_ASSERT_SAME(a_pop_valid, clk, rst, q_pop, q_stat.valid,
    "back stage popped an empty queue")

  // A transferred result with nothing queued behind it leaves the output empty.
  `SETSEQ_ASSERT_NEXT(a_out_drain, clk, rst, out_valid && !out_stall && !q_stat.valid,
    !out_valid, "output register refilled with no queued item")

endmodule

// ===== tb/tb_seismic_event_trigger_sequencer.sv =====
// ----------------------------------------------------------------------------
// Seismic event trigger sequencer testbench
// Sends sample sets under random valid and stall gaps. A scoreboard predicts
// each result from its own copy of the registers and the sequence state and
// checks every field of every result that comes out of the block.
// ----------------------------------------------------------------------------
module tb_seismic_event_trigger_sequencer;

  localparam int RAW_W      = setseq_pkg::RAW_W;
  localparam int SAMPLE_W   = setseq_pkg::SAMPLE_W;
  localparam int LEVEL_W    = setseq_pkg::LEVEL_W;
  localparam int RECLEN_W   = setseq_pkg::RECLEN_W;
  localparam int MODES_W    = setseq_pkg::MODES_W;
  localparam int CALCNT_W   = setseq_pkg::CALCNT_W;
  localparam int MANCNT_W   = setseq_pkg::MANCNT_W;
  localparam int CFG_IDX_W  = setseq_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = setseq_pkg::CFG_DATA_W;
  localparam int CAL_UNIT   = setseq_pkg::CAL_UNIT;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 5;
  localparam int CYCLE_LIMIT  = 1000000;
  // A result passes the front register, the queue and the output register; the drain covers its tail.
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 120;
  localparam int IDLE_PCT     = 15;
  localparam int PHASE_ITEMS  = 210;
  localparam int RANDOM_PHASES = 8;

  // Alarm mode field codes, two bits per alarm.
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_SEISMIC = 2'd1;
  localparam logic [1:0] MODE_AIR     = 2'd2;
  localparam logic [1:0] MODE_BOTH    = 2'd3;

  localparam logic [SAMPLE_W-1:0] MID_CODE = 12'h800;
  localparam logic [LEVEL_W-1:0]  LEVEL_DEFAULT  = 12'd2048;
  localparam logic [RECLEN_W-1:0] RECLEN_DEFAULT = 24'd1024;
  localparam logic [LEVEL_W-1:0]  LEVEL_NEVER    = 12'd4095;
  localparam logic [RECLEN_W-1:0] RECLEN_MAX     = 24'hFFFFFF;

  // Points of the calibration pulse, counted down in units of CAL_UNIT.
  localparam logic [CALCNT_W-1:0] PULSE_START    = CALCNT_W'(100 * CAL_UNIT);
  localparam logic [CALCNT_W-1:0] PULSE_SIG_FALL = CALCNT_W'(91 * CAL_UNIT);
  localparam logic [CALCNT_W-1:0] PULSE_SIG_RISE = CALCNT_W'(73 * CAL_UNIT);
  localparam logic [CALCNT_W-1:0] PULSE_EN_FALL  = CALCNT_W'(64 * CAL_UNIT);
  localparam logic [MANCNT_W-1:0] MANUAL_LAST    = MANCNT_W'(99);

  typedef struct packed {
    logic [RAW_W-1:0] air;
    logic [RAW_W-1:0] seis1;
    logic [RAW_W-1:0] seis2;
    logic [RAW_W-1:0] seis3;
    logic             manual;
  } sample_set_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] air;
    logic [SAMPLE_W-1:0] seis1;
    logic [SAMPLE_W-1:0] seis2;
    logic [SAMPLE_W-1:0] seis3;
    setseq_pkg::marker_t marker;
    logic                cal_enable;
    logic                cal_signal;
  } event_result_t;

  // Scoreboard: tracks the registers and the sequence state, predicts one
  // result per accepted sample set and checks results in arrival order.
  class trigger_scoreboard;
    logic [LEVEL_W-1:0]  trig_seis, trig_air, a1_seis, a1_air, a2_seis, a2_air;
    logic [RECLEN_W-1:0] rec_len;
    logic [MODES_W-1:0]  modes;
    bit                  recording, cal_on, en_level, sig_level;
    logic [RECLEN_W-1:0] rec_left;
    logic [CALCNT_W-1:0] cal_left;
    logic [MANCNT_W-1:0] manual_cnt;
    event_result_t       expected_q[$];
    int                  errors;

    function new();
      trig_seis  = LEVEL_DEFAULT;
      trig_air   = LEVEL_DEFAULT;
      a1_seis    = LEVEL_DEFAULT;
      a1_air     = LEVEL_DEFAULT;
      a2_seis    = LEVEL_DEFAULT;
      a2_air     = LEVEL_DEFAULT;
      rec_len    = RECLEN_DEFAULT;
      modes      = '0;
      recording  = 1'b0;
      cal_on     = 1'b0;
      en_level   = 1'b0;
      sig_level  = 1'b0;
      rec_left   = '0;
      cal_left   = '0;
      manual_cnt = '0;
      errors     = 0;
    endfunction

    function void set_reg(setseq_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        setseq_pkg::REG_TRIG_SEIS:  trig_seis = value[LEVEL_W-1:0];
        setseq_pkg::REG_TRIG_AIR:   trig_air  = value[LEVEL_W-1:0];
        setseq_pkg::REG_REC_LEN:    rec_len   = value[RECLEN_W-1:0];
        setseq_pkg::REG_ALARM_MODE: modes     = value[MODES_W-1:0];
        setseq_pkg::REG_A1_SEIS:    a1_seis   = value[LEVEL_W-1:0];
        setseq_pkg::REG_A1_AIR:     a1_air    = value[LEVEL_W-1:0];
        setseq_pkg::REG_A2_SEIS:    a2_seis   = value[LEVEL_W-1:0];
        setseq_pkg::REG_A2_AIR:     a2_air    = value[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [LEVEL_W-1:0] dist_from_mid(logic [SAMPLE_W-1:0] s);
      return (s > MID_CODE) ? s - MID_CODE : MID_CODE - s;
    endfunction

    // Element 0 of mag is the air channel, 1 to 3 the seismic channels.
    function bit over_level(logic [1:0] mode, logic [3:0][LEVEL_W-1:0] mag,
                            logic [LEVEL_W-1:0] seis_lvl, logic [LEVEL_W-1:0] air_lvl);
      bit hit;
      hit = 1'b0;
      if (mode == MODE_SEISMIC || mode == MODE_BOTH) begin
        if (mag[1] > seis_lvl || mag[2] > seis_lvl || mag[3] > seis_lvl) hit = 1'b1;
      end
      if (mode == MODE_AIR || mode == MODE_BOTH) begin
        if (mag[0] > air_lvl) hit = 1'b1;
      end
      return hit;
    endfunction

    function void note_sample(sample_set_t smp);
      event_result_t r;
      logic [3:0][LEVEL_W-1:0] mag;
      r.air    = smp.air[RAW_W-1:4];
      r.seis1  = smp.seis1[RAW_W-1:4];
      r.seis2  = smp.seis2[RAW_W-1:4];
      r.seis3  = smp.seis3[RAW_W-1:4];
      r.marker = setseq_pkg::MARK_NONE;
      mag[0] = dist_from_mid(r.air);
      mag[1] = dist_from_mid(r.seis1);
      mag[2] = dist_from_mid(r.seis2);
      mag[3] = dist_from_mid(r.seis3);
      if (smp.manual) begin
        if (manual_cnt == '0) r.marker = setseq_pkg::MARK_CAL_START;
        else if (manual_cnt == MANUAL_LAST) r.marker = setseq_pkg::MARK_CAL_END;
        manual_cnt = manual_cnt + 1'b1;
      end else begin
        manual_cnt = '0;
        if (!recording && !cal_on) begin
          if (over_level(MODE_BOTH, mag, trig_seis, trig_air)) begin
            recording = 1'b1;
            rec_left  = rec_len;
            r.marker  = setseq_pkg::MARK_TRIGGER;
          end
        end else if (recording && rec_left != '0) begin
          rec_left = rec_left - 1'b1;
          if (over_level(modes[3:2], mag, a2_seis, a2_air)) begin
            r.marker = setseq_pkg::MARK_ALARM2;
          end else if (over_level(modes[1:0], mag, a1_seis, a1_air)) begin
            r.marker = setseq_pkg::MARK_ALARM1;
          end
        end else if (recording) begin
          recording = 1'b0;
          cal_on    = 1'b1;
          cal_left  = PULSE_START;
          en_level  = 1'b1;
          r.marker  = setseq_pkg::MARK_CAL_START;
        end else if (cal_left != '0) begin
          if (cal_left == PULSE_START) begin
            en_level  = 1'b1;
            sig_level = 1'b1;
          end
          if (cal_left == PULSE_SIG_FALL) sig_level = 1'b0;
          if (cal_left == PULSE_SIG_RISE) sig_level = 1'b1;
          if (cal_left == PULSE_EN_FALL) en_level = 1'b0;
          cal_left = cal_left - 1'b1;
        end else begin
          cal_on = 1'b0;
        end
      end
      r.cal_enable = en_level;
      r.cal_signal = sig_level;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(event_result_t got);
      event_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("air_out", want.air, got.air);
      compare_field("seis1_out", want.seis1, got.seis1);
      compare_field("seis2_out", want.seis2, got.seis2);
      compare_field("seis3_out", want.seis3, got.seis3);
      compare_field("marker", want.marker, got.marker);
      compare_field("cal_enable", want.cal_enable, got.cal_enable);
      compare_field("cal_signal", want.cal_signal, got.cal_signal);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [RAW_W-1:0]      air_raw;
  logic [RAW_W-1:0]      seis1_raw;
  logic [RAW_W-1:0]      seis2_raw;
  logic [RAW_W-1:0]      seis3_raw;
  logic                  manual_cal;
  logic                  out_valid;
  logic                  out_stall;
  logic [SAMPLE_W-1:0]   air_out;
  logic [SAMPLE_W-1:0]   seis1_out;
  logic [SAMPLE_W-1:0]   seis2_out;
  logic [SAMPLE_W-1:0]   seis3_out;
  logic [2:0]            marker;
  logic                  cal_enable;
  logic                  cal_signal;

  trigger_scoreboard sb;
  event_result_t     observed;
  int unsigned       cycle_count;
  int unsigned       manual_left;
  // When calm is set, neither side inserts idle cycles.
  bit                calm;
  // A request for one long output hold-off, served by the receiver process.
  bit                hold_request;
  bit                hold_done;

  seismic_event_trigger_sequencer i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .air_raw    (air_raw),
    .seis1_raw  (seis1_raw),
    .seis2_raw  (seis2_raw),
    .seis3_raw  (seis3_raw),
    .manual_cal (manual_cal),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .air_out    (air_out),
    .seis1_out  (seis1_out),
    .seis2_out  (seis2_out),
    .seis3_out  (seis3_out),
    .marker     (marker),
    .cal_enable (cal_enable),
    .cal_signal (cal_signal)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // The run ends here if the block stops making progress.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver side. It stalls at random, except during the calm stretch, and
  // once holds off for a long stretch so that the block backs up and stalls
  // its input while the sender keeps offering sample sets.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Every result transfer is checked against the oldest prediction. Values
  // are read right after the edge, before any update of that edge lands.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      observed.air        = air_out;
      observed.seis1      = seis1_out;
      observed.seis2      = seis2_out;
      observed.seis3      = seis3_out;
      observed.marker     = setseq_pkg::marker_t'(marker);
      observed.cal_enable = cal_enable;
      observed.cal_signal = cal_signal;
      sb.check_result(observed);
    end
  end

  function automatic sample_set_t sample_set(logic [RAW_W-1:0] a, logic [RAW_W-1:0] s1,
                                             logic [RAW_W-1:0] s2, logic [RAW_W-1:0] s3,
                                             logic m);
    sample_set_t smp;
    smp.air    = a;
    smp.seis1  = s1;
    smp.seis2  = s2;
    smp.seis3  = s3;
    smp.manual = m;
    return smp;
  endfunction

  // Mostly quiet samples near mid-scale, with spikes and full-scale values
  // mixed in so that the trigger and alarm levels are crossed now and then.
  function automatic logic [RAW_W-1:0] random_raw();
    logic [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 19))
      0: s = '0;
      1: s = '1;
      2, 3, 4: s = SAMPLE_W'($urandom_range(0, 4095));
      5, 6: s = SAMPLE_W'($urandom_range(1648, 2448));
      default: s = SAMPLE_W'($urandom_range(2008, 2088));
    endcase
    return {s, 4'($urandom)};
  endfunction

  // Manual calibrations come in bursts: short ones, and long ones of which some
  // reach the end marker.
  function automatic sample_set_t random_sample();
    logic m;
    if (manual_left == 0 && $urandom_range(0, 99) == 0) begin
      if ($urandom_range(0, 4) == 0) manual_left = $urandom_range(95, 104);
      else manual_left = $urandom_range(1, 6);
    end
    m = (manual_left != 0);
    if (manual_left != 0) manual_left--;
    return sample_set(random_raw(), random_raw(), random_raw(), random_raw(), m);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_level();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return CFG_DATA_W'(LEVEL_DEFAULT);
      2: return CFG_DATA_W'(LEVEL_NEVER);
      // The upper data bits are not part of a level register.
      3: return {12'($urandom), 12'($urandom_range(0, 2048))};
      default: return CFG_DATA_W'($urandom_range(10, 400));
    endcase
  endfunction

  // One sample set transfer, with random idle cycles in front of it.
  task automatic send_sample(sample_set_t smp);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    air_raw    <= smp.air;
    seis1_raw  <= smp.seis1;
    seis2_raw  <= smp.seis2;
    seis3_raw  <= smp.seis3;
    manual_cal <= smp.manual;
    do @(posedge clk); while (in_stall);
    sb.note_sample(smp);
  endtask

  // Stop sending and wait for every predicted result to come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(setseq_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
  endtask

  task automatic program_all(logic [CFG_DATA_W-1:0] ts, logic [CFG_DATA_W-1:0] ta,
                             logic [CFG_DATA_W-1:0] len, logic [CFG_DATA_W-1:0] modes,
                             logic [CFG_DATA_W-1:0] a1s, logic [CFG_DATA_W-1:0] a1a,
                             logic [CFG_DATA_W-1:0] a2s, logic [CFG_DATA_W-1:0] a2a);
    write_reg(setseq_pkg::REG_TRIG_SEIS, ts);
    write_reg(setseq_pkg::REG_TRIG_AIR, ta);
    write_reg(setseq_pkg::REG_REC_LEN, len);
    write_reg(setseq_pkg::REG_ALARM_MODE, modes);
    write_reg(setseq_pkg::REG_A1_SEIS, a1s);
    write_reg(setseq_pkg::REG_A1_AIR, a1a);
    write_reg(setseq_pkg::REG_A2_SEIS, a2s);
    write_reg(setseq_pkg::REG_A2_AIR, a2a);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] len;
    logic [CFG_DATA_W-1:0] modes;
    sb           = new();
    manual_left  = 0;
    calm         = 1'b0;
    hold_request = 1'b0;
    hold_done    = 1'b0;
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    cfg_index    <= setseq_pkg::REG_TRIG_SEIS;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    air_raw      <= '0;
    seis1_raw    <= '0;
    seis2_raw    <= '0;
    seis3_raw    <= '0;
    manual_cal   <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset levels sit at full scale: even the largest magnitude, 2048 at
    // code zero, does not exceed them, so nothing triggers here.
    send_sample(sample_set(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_sample(sample_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    send_sample(sample_set(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    send_sample(sample_set(16'h800F, 16'h7FFF, 16'h8010, 16'h7FF0, 1'b0));
    send_sample(sample_set(16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0, 1'b0));
    send_sample(sample_set(16'h5555, 16'hAAAA, 16'hF0F0, 16'h0F0F, 1'b0));
    // A manual calibration marks its start, then is restarted.
    send_sample(sample_set(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
    send_sample(sample_set(16'h0000, 16'hFFFF, 16'h8000, 16'h8000, 1'b1));
    send_sample(sample_set(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
    send_sample(sample_set(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    send_sample(sample_set(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
    send_sample(sample_set(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    settle();

    // Seismic trigger just above its level, air level out of reach, and a
    // zero record length so the next sample starts the calibration.
    program_all(24'd100, CFG_DATA_W'(LEVEL_NEVER), '0, 24'hF, '0, '0, '0, '0);
    send_sample(sample_set(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    send_sample(sample_set(16'h0000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    send_sample(sample_set(16'h8000, 16'h8640, 16'h8000, 16'h8000, 1'b0));
    send_sample(sample_set(16'h8000, 16'h8000, 16'h8650, 16'h8000, 1'b0));
    send_sample(sample_set(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    send_sample(sample_set(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    // A manual calibration in the middle of the pulse holds the sequence.
    send_sample(sample_set(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
    send_sample(sample_set(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    send_sample(sample_set(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0));

    // Random phases, each under a fresh register setting. The sender pauses
    // at every phase boundary until all results are back.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        3: len = '0;
        4: len = 24'd1;
        default: len = CFG_DATA_W'($urandom_range(0, 30));
      endcase
      case (p)
        1: modes = '0;
        2: modes = 24'hF;
        default: modes = CFG_DATA_W'($urandom_range(0, 15));
      endcase
      program_all(random_level(), random_level(), len, modes,
                  random_level(), random_level(), random_level(), random_level());
      hold_request = (p == 2);
      calm = (p == 5);
      repeat (PHASE_ITEMS) send_sample(random_sample());
      calm = 1'b0;
    end

    // Longest record length: a trigger here records to the end of the run.
    settle();
    program_all(CFG_DATA_W'($urandom_range(20, 300)), CFG_DATA_W'($urandom_range(20, 300)),
                CFG_DATA_W'(RECLEN_MAX), CFG_DATA_W'($urandom_range(0, 15)),
                random_level(), random_level(), random_level(), random_level());
    repeat (PHASE_ITEMS) send_sample(random_sample());

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
